/* rtl/infix_to_postfix_converter_core_macros.svh */
// Assertion macros used by the checker file of the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ITPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itpc assertion failed");

// Next-cycle implication, switched off while reset is held.
`define ITPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itpc assertion failed");

// Next-cycle implication that also holds across reset.
`define ITPC_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("itpc assertion failed");

`endif

/* rtl/itpc_pkg.sv */
// Types, codes and defaults shared by the infix to postfix converter.
`default_nettype none

package itpc_pkg;

    localparam int KIND_W      = 3;
    localparam int VALUE_W     = 16;
    localparam int PRIO_W      = 4;
    localparam int OKIND_W     = 2;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [KIND_W-1:0] {
        TK_TERM  = 3'd0,
        TK_OPER  = 3'd1,
        TK_OPEN  = 3'd2,
        TK_CLOSE = 3'd3,
        TK_END   = 3'd4
    } t_tok_kind;

    typedef enum logic [OKIND_W-1:0] {
        OK_NONE = 2'd0,
        OK_TERM = 2'd1,
        OK_OPER = 2'd2,
        OK_ERR  = 2'd3
    } t_out_kind;

    typedef enum logic [2:0] {
        CC_TERM,
        CC_OPER,
        CC_OPEN,
        CC_CLOSE,
        CC_END,
        CC_SKIP
    } t_cmd_class;

    typedef struct packed {
        t_cmd_class               cls;
        logic [VALUE_W-1:0]       value;
        logic [PRIO_W-1:0]        prio;
    } t_cmd;

    typedef struct packed {
        logic                     bracket;
        logic [VALUE_W-1:0]       value;
        logic [PRIO_W-1:0]        prio;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/itpc_ifs.sv */
// Token and result channel interfaces of the infix to postfix converter.
`default_nettype none

interface itpc_token_if;
    logic                          valid;
    logic                          ready;
    logic [itpc_pkg::KIND_W-1:0]   token_kind;
    logic [itpc_pkg::VALUE_W-1:0]  token_value;
    logic [itpc_pkg::PRIO_W-1:0]   op_priority;

    modport source (output valid, output token_kind, output token_value,
                    output op_priority, input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input op_priority, output ready);
endinterface

interface itpc_result_if;
    logic                          valid;
    logic                          ready;
    logic [itpc_pkg::OKIND_W-1:0]  out_kind;
    logic [itpc_pkg::VALUE_W-1:0]  out_value;
    logic                          last;

    modport source (output valid, output out_kind, output out_value,
                    output last, input ready);
    modport sink   (input valid, input out_kind, input out_value,
                    input last, output ready);
endinterface

`default_nettype wire

/* rtl/itpc_front.sv */
// Front end: accepts tokens and classifies them into stack commands.
`default_nettype none

module itpc_front (
    itpc_token_if.sink       i_tok,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output itpc_pkg::t_cmd   o_q_cmd
);
    import itpc_pkg::*;

    t_cmd_class cls;

    always_comb begin
        unique case (t_tok_kind'(i_tok.token_kind))
            TK_TERM:  cls = CC_TERM;
            TK_OPER:  cls = CC_OPER;
            TK_OPEN:  cls = CC_OPEN;
            TK_CLOSE: cls = CC_CLOSE;
            TK_END:   cls = CC_END;
            default:  cls = CC_SKIP;
        endcase
    end

    assign i_tok.ready   = !i_q_full;
    assign o_q_push      = i_tok.valid && !i_q_full;
    assign o_q_cmd.cls   = cls;
    assign o_q_cmd.value = i_tok.token_value;
    assign o_q_cmd.prio  = i_tok.op_priority;

endmodule

`default_nettype wire

/* rtl/itpc_queue.sv */
// Short command queue between the front end and the stack engine.
`default_nettype none

module itpc_queue #(
    parameter int DEPTH = itpc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  itpc_pkg::t_cmd        i_cmd,
    output logic                  o_full,
    output logic                  o_valid,
    output itpc_pkg::t_cmd        o_cmd,
    input  wire logic             i_pop
);
    import itpc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_buf [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_buf[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/itpc_back.sv */
// Stack engine: pops, pushes and emits results one step per cycle while the result output is not stalled.
`default_nettype none

module itpc_back #(
    parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  itpc_pkg::t_cmd        i_q_cmd,
    output logic                  o_q_pop,
    itpc_result_if.source         o_res
);
    import itpc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    // The top entry lives in r_top; the memory holds the entries below it,
    // and r_below always mirrors the entry just under the top.
    t_entry              r_mem [STACK_DEPTH];
    t_entry              r_top, n_top;
    t_entry              r_below;
    logic [CW-1:0]       r_count, n_count;
    logic                r_any;
    logic                r_ov;
    t_out_kind           r_okind;
    logic [VALUE_W-1:0]  r_oval;
    logic                r_olast;

    logic                can_emit, go, done;
    logic                emit, e_last;
    t_out_kind           e_kind;
    logic [VALUE_W-1:0]  e_val;
    logic                cnt_nz, cnt_ge2, cnt_one, full, top_op, pop_ok, below_hi;
    logic                wr_en;
    logic [IW-1:0]       wr_addr, rd_addr;
    logic [CW-1:0]       cnt_m1, n_cnt_m2;
    t_entry              push_entry;

    assign can_emit = !r_ov || o_res.ready;
    assign go       = i_q_valid && can_emit;
    assign cnt_nz   = (r_count != '0);
    assign cnt_one  = (r_count == CW'(1));
    assign cnt_ge2  = cnt_nz && !cnt_one;
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign top_op   = cnt_nz && !r_top.bracket;
    assign below_hi = cnt_ge2 && !r_below.bracket && (r_below.prio >= i_q_cmd.prio);
    assign cnt_m1   = r_count - CW'(1);
    assign wr_addr  = cnt_m1[IW-1:0];
    assign n_cnt_m2 = n_count - CW'(2);
    assign rd_addr  = (n_count > CW'(1)) ? n_cnt_m2[IW-1:0] : '0;

    always_comb begin
        push_entry.bracket = (i_q_cmd.cls == CC_OPEN);
        push_entry.value   = (i_q_cmd.cls == CC_OPEN) ? '0 : i_q_cmd.value;
        push_entry.prio    = (i_q_cmd.cls == CC_OPEN) ? '0 : i_q_cmd.prio;
    end

    always_comb begin
        case (i_q_cmd.cls) inside
            CC_OPER:          pop_ok = top_op && (r_top.prio >= i_q_cmd.prio);
            CC_CLOSE, CC_END: pop_ok = top_op;
            default:          pop_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        emit    = 1'b0;
        e_kind  = OK_NONE;
        e_val   = '0;
        e_last  = 1'b1;
        done    = 1'b0;
        wr_en   = 1'b0;
        if (go) begin
            if (pop_ok) begin
                emit    = 1'b1;
                e_kind  = OK_OPER;
                e_val   = r_top.value;
                n_count = cnt_m1;
                n_top   = r_below;
                case (i_q_cmd.cls)
                    CC_OPER:  e_last = !below_hi;
                    CC_CLOSE: e_last = cnt_ge2 && r_below.bracket;
                    default:  e_last = cnt_one;
                endcase
            end else begin
                done = 1'b1;
                case (i_q_cmd.cls) inside
                    CC_TERM: begin
                        emit   = 1'b1;
                        e_kind = OK_TERM;
                        e_val  = i_q_cmd.value;
                    end
                    CC_OPER, CC_OPEN: begin
                        if (full) begin
                            n_count = '0;
                            emit    = 1'b1;
                            e_kind  = OK_ERR;
                        end else begin
                            wr_en   = cnt_nz;
                            n_top   = push_entry;
                            n_count = r_count + CW'(1);
                            emit    = !r_any;
                        end
                    end
                    CC_CLOSE: begin
                        if (!cnt_nz) begin
                            emit   = 1'b1;
                            e_kind = OK_ERR;
                        end else begin
                            n_count = cnt_m1;
                            n_top   = r_below;
                            emit    = !r_any;
                        end
                    end
                    CC_END: begin
                        if (cnt_nz) begin
                            n_count = '0;
                            emit    = 1'b1;
                            e_kind  = OK_ERR;
                        end else begin
                            emit = !r_any;
                        end
                    end
                    default: begin
                        emit = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_q_pop = go && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_any   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (go) begin
                r_any <= done ? 1'b0 : (r_any || emit);
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (emit) begin
            r_okind <= e_kind;
            r_oval  <= e_val;
            r_olast <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            r_below <= r_top;
        end else begin
            r_below <= r_mem[rd_addr];
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.out_kind  = r_okind;
    assign o_res.out_value = r_oval;
    assign o_res.last      = r_olast;

endmodule

`default_nettype wire

/* rtl/infix_to_postfix_converter_core.sv */
// Top level of the infix to postfix converter: front end, queue and stack engine.
//
//  Channel   Direction  Transaction
//  i_tok     in         token_kind, token_value, op_priority
//  o_res     out        out_kind, out_value, last
//
// A term, open bracket or ignored token is handled by the stack engine on
// its own; an operator, close bracket or end marker first pops each operator
// that gives way to it, then is taken. Results leave through a single output
// register, one per cycle at most. Reset clears the stack count, the queue
// and the output valid flag at once. A stalled result holds the engine
// while the queue keeps taking tokens until it is full.
`default_nettype none

module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEF,
    parameter int QUEUE_DEPTH = itpc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    itpc_token_if.sink       i_tok,
    itpc_result_if.source    o_res
);
    import itpc_pkg::*;

    logic  q_push, q_full, q_valid, q_pop;
    t_cmd  q_in_cmd, q_out_cmd;

    itpc_front u_front (
        .i_tok    (i_tok),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in_cmd)
    );

    itpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    itpc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_out_cmd),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

/* rtl/itpc_checker.sv */
// Port-level assertions for the infix to postfix converter and their binding.
`default_nettype none

`include "infix_to_postfix_converter_core_macros.svh"

module itpc_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_res_valid,
    input  wire logic                          i_res_ready,
    input  wire logic [itpc_pkg::OKIND_W-1:0]  i_out_kind,
    input  wire logic [itpc_pkg::VALUE_W-1:0]  i_out_value,
    input  wire logic                          i_last
);
    import itpc_pkg::*;

    `ITPC_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_out_kind) && $stable(i_out_value) && $stable(i_last))
    `ITPC_ASSERT_IMPLY(a_none_err_last, i_clk, i_rst_n, i_res_valid && (i_out_kind == OK_NONE || i_out_kind == OK_ERR), i_last && (i_out_value == '0))
    `ITPC_ASSERT_IMPLY(a_term_last, i_clk, i_rst_n, i_res_valid && (i_out_kind == OK_TERM), i_last)
    `ITPC_ASSERT_ALWAYS_NEXT(a_reset_quiet, i_clk, !i_rst_n, !i_res_valid)

endmodule

bind infix_to_postfix_converter_core itpc_checker u_itpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_out_kind  (o_res.out_kind),
    .i_out_value (o_res.out_value),
    .i_last      (o_res.last)
);

`default_nettype wire
